// ===== src/min_plus_matrix_power_assert.svh =====
// Assertion macros for the min-plus matrix power block.
`ifndef MIN_PLUS_MATRIX_POWER_ASSERT_SVH
`define MIN_PLUS_MATRIX_POWER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mpmp_pkg.sv =====
// Shared types and codes for the min-plus matrix power block.
`timescale 1ns / 1ps
package mpmp_pkg;

  localparam int EntryW  = 25;
  localparam int WeightW = 24;

  typedef logic [EntryW-1:0] entry_t;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_POWER        = 1'b1;

  // Control travelling with each read beat into the min-plus accumulator.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic is_copy;
  } acc_ctl_t;

endpackage

// ===== src/mpmp_minacc.sv =====
// Min-plus accumulator: saturating add of two entries and running minimum, or x passed through on copy beats.
`timescale 1ns / 1ps
module mpmp_minacc (
  input  logic              clk,
  input  mpmp_pkg::acc_ctl_t ctl,
  input  mpmp_pkg::entry_t  x,
  input  mpmp_pkg::entry_t  y,
  output mpmp_pkg::entry_t  wr_data
);
  import mpmp_pkg::*;

  entry_t              acc_r;
  entry_t              best;
  logic [WeightW:0]    sum;
  logic [WeightW-1:0]  sat;
  logic                term;

  always_comb begin
    sum  = {1'b0, x[WeightW-1:0]} + {1'b0, y[WeightW-1:0]};
    sat  = sum[WeightW] ? {WeightW{1'b1}} : sum[WeightW-1:0];
    term = x[WeightW] & y[WeightW];
    if (ctl.first) begin
      best = term ? {1'b1, sat} : '0;
    end else if (term && (!acc_r[WeightW] || sat < acc_r[WeightW-1:0])) begin
      best = {1'b1, sat};
    end else begin
      best = acc_r;
    end
    wr_data = ctl.is_copy ? x : best;
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      acc_r <= best;
    end
  end

endmodule

// ===== src/min_plus_matrix_power.sv =====
// Top level: min-plus matrix power by squaring over three entry memories.
// Write item: result registered in the cycle after the beat, one write per cycle while the output slot is free or
//   emptying; read item: looked up in S_READ, then registered into the output slot. Compute item: every pass
//   sweeps the active n x n square through registered-read memories, one k term per cycle in the
//   accumulator; about 2*log2(power) products plus copies, then one result beat.
// Reset (rst_n low, synchronous) starts a pass that clears every entry of the matrix store,
//   during which no item is taken.
`timescale 1ns / 1ps
module min_plus_matrix_power #(
  parameter int MAX_VERTICES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: row[3:0], col[7:4], weight[23:8], present[24], zero fill
  input  logic [31:0] in_tdata,
  // in_tuser: op[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: path_weight[23:0], path_exists[24], zero fill
  output logic [31:0] out_tdata,
  // out_tuser: op_done[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import mpmp_pkg::*;

  localparam int Depth = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(Depth);
  localparam int IW    = $clog2(MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_RUN, S_DRAIN, S_ODD, S_SHIFT, S_RESP
  } state_t;

  // Pass kinds: copies between stores and products into scratch.
  typedef enum logic [2:0] {
    P_COPY_M2B, P_MUL_MB, P_COPY_S2M, P_COPY_B2M, P_SQR_B, P_COPY_S2B
  } pass_t;

  // Configuration registers
  logic [4:0] vcount_r;
  logic [7:0] power_r;

  state_t        state_r;
  pass_t         pass_r;
  logic [AW-1:0] clr_r;
  logic [NW-1:0] n_r;
  logic [7:0]    exp_r;      // exponent bits still to consume
  logic          have_r;     // accumulator in matrix store is valid
  logic [IW-1:0] i_r, j_r, k_r;
  logic          rd_inside_r;

  // Read-beat pipeline stage, registered from the address issue alongside the memory reads
  acc_ctl_t      ctl1_r;
  logic [AW-1:0] addr1_r;

  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  // Memories
  entry_t mat_mem  [Depth];
  entry_t base_mem [Depth];
  entry_t scr_mem  [Depth];
  entry_t mat_q, base0_q, base1_q, scr_q;

  logic [3:0]    in_row, in_col;
  logic [15:0]   in_weight;
  logic          in_present;
  logic [1:0]    in_op;
  logic          in_acc, item_inside, out_set;
  logic [AW-1:0] item_addr, ij_addr, a_addr, b_addr;
  logic [AW-1:0] mat_raddr, base0_raddr;
  logic          is_prod, k_last, j_last, i_last;
  logic [NW-1:0] n_last, n_eff;

  logic          mat_we, base_we, scr_we;
  logic [AW-1:0] mat_waddr;
  entry_t        mat_wdata, acc_wdata, x_sel;

  assign in_row     = in_tdata[3:0];
  assign in_col     = in_tdata[7:4];
  assign in_weight  = in_tdata[23:8];
  assign in_present = in_tdata[24];
  assign in_op      = in_tuser;

  // One item at a time; the output slot must be empty or emptying.
  assign in_tready = (state_r == S_IDLE) && (!out_tvalid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // A result beat is posted by a write beat, a read lookup or a finished compute
  assign out_set = (state_r == S_READ) || (state_r == S_RESP)
                || (in_acc && in_op == OP_WRITE);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign item_inside = (int'(in_row) < MAX_VERTICES) && (int'(in_col) < MAX_VERTICES);
  assign item_addr   = AW'(int'(in_row) * MAX_VERTICES + int'(in_col));
  assign ij_addr     = AW'(int'(i_r) * MAX_VERTICES + int'(j_r));
  assign a_addr      = AW'(int'(i_r) * MAX_VERTICES + int'(k_r));
  assign b_addr      = AW'(int'(k_r) * MAX_VERTICES + int'(j_r));

  // Active side, limited to the store
  assign n_eff  = (int'(vcount_r) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount_r);
  assign n_last = NW'(n_r - NW'(1));

  assign is_prod = (pass_r == P_MUL_MB) || (pass_r == P_SQR_B);
  assign k_last  = !is_prod || (NW'(k_r) == n_last);
  assign j_last  = NW'(j_r) == n_last;
  assign i_last  = NW'(i_r) == n_last;

  assign mat_raddr   = (state_r == S_IDLE) ? item_addr
                     : ((pass_r == P_MUL_MB) ? a_addr : ij_addr);
  assign base0_raddr = (pass_r == P_SQR_B) ? a_addr : ij_addr;

  // Operand / copy source by pass
  always_comb begin
    case (pass_r)
      P_COPY_M2B: x_sel = mat_q;
      P_MUL_MB:   x_sel = mat_q;
      P_COPY_B2M: x_sel = base0_q;
      P_SQR_B:    x_sel = base0_q;
      P_COPY_S2M: x_sel = scr_q;
      P_COPY_S2B: x_sel = scr_q;
      default:    x_sel = scr_q;
    endcase
  end

  mpmp_minacc u_minacc (
    .clk     (clk),
    .ctl     (ctl1_r),
    .x       (x_sel),
    .y       (base1_q),
    .wr_data (acc_wdata)
  );

  // Write steering: clear, item writes, then pass results by destination
  always_comb begin
    mat_we    = 1'b0;
    mat_waddr = addr1_r;
    mat_wdata = acc_wdata;
    base_we   = 1'b0;
    scr_we    = 1'b0;
    if (state_r == S_CLEAR) begin
      mat_we    = 1'b1;
      mat_waddr = clr_r;
      mat_wdata = '0;
    end else if (in_acc && in_op == OP_WRITE && item_inside) begin
      mat_we    = 1'b1;
      mat_waddr = item_addr;
      mat_wdata = in_present ? {1'b1, 8'd0, in_weight} : '0;
    end else if (ctl1_r.valid && ctl1_r.last) begin
      case (pass_r)
        P_COPY_S2M, P_COPY_B2M: mat_we  = 1'b1;
        P_COPY_M2B, P_COPY_S2B: base_we = 1'b1;
        P_MUL_MB, P_SQR_B:      scr_we  = 1'b1;
        default:                scr_we  = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= mat_wdata;
    end
    mat_q <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (base_we) begin
      base_mem[addr1_r] <= acc_wdata;
    end
    base0_q <= base_mem[base0_raddr];
    base1_q <= base_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[addr1_r] <= acc_wdata;
    end
    scr_q <= scr_mem[ij_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      pass_r       <= P_COPY_M2B;
      clr_r        <= '0;
      vcount_r     <= 5'd16;
      power_r      <= 8'd16;
      exp_r        <= '0;
      have_r       <= 1'b0;
      n_r          <= '0;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      ctl1_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_VERTEX_COUNT) begin
          vcount_r <= cfg_data[4:0];
        end else begin
          power_r <= cfg_data;
        end
      end

      // result slot: set by a new beat, held until the receiver takes it
      out_tvalid_r <= out_set || (out_tvalid_r && !out_tready);

      ctl1_r.valid <= (state_r == S_RUN);

      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (int'(clr_r) == Depth - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            case (in_op)
              OP_WRITE: begin
                out_tdata_r  <= '0;
                out_tuser_r  <= OP_WRITE;
              end
              OP_COMPUTE: begin
                n_r    <= n_eff;
                exp_r  <= (power_r == 8'd0) ? 8'd1 : power_r;
                have_r <= 1'b0;
                pass_r <= P_COPY_M2B;
                i_r    <= '0;
                j_r    <= '0;
                k_r    <= '0;
                state_r <= (n_eff == '0) ? S_RESP : S_RUN;
              end
              OP_READ: begin
                rd_inside_r <= item_inside;
                state_r     <= S_READ;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          out_tuser_r  <= OP_READ;
          if (rd_inside_r && mat_q[WeightW]) begin
            out_tdata_r <= {7'd0, 1'b1, mat_q[WeightW-1:0]};
          end else begin
            out_tdata_r <= '0;
          end
          state_r <= S_IDLE;
        end
        S_RUN: begin
          ctl1_r.first   <= (k_r == '0);
          ctl1_r.last    <= k_last;
          ctl1_r.is_copy <= !is_prod;
          addr1_r        <= ij_addr;
          if (!k_last) begin
            k_r <= k_r + IW'(1);
          end else begin
            k_r <= '0;
            if (!j_last) begin
              j_r <= j_r + IW'(1);
            end else begin
              j_r <= '0;
              if (!i_last) begin
                i_r <= i_r + IW'(1);
              end else begin
                i_r     <= '0;
                state_r <= S_DRAIN;
              end
            end
          end
        end
        S_DRAIN: begin
          // final write of the pass lands this cycle
          case (pass_r)
            P_COPY_M2B: state_r <= S_ODD;
            P_MUL_MB: begin
              pass_r  <= P_COPY_S2M;
              state_r <= S_RUN;
            end
            P_COPY_S2M, P_COPY_B2M: state_r <= S_SHIFT;
            P_SQR_B: begin
              pass_r  <= P_COPY_S2B;
              state_r <= S_RUN;
            end
            P_COPY_S2B: state_r <= S_ODD;
            default:    state_r <= S_RESP;
          endcase
        end
        S_ODD: begin
          if (exp_r[0]) begin
            state_r <= S_RUN;
            if (have_r) begin
              pass_r <= P_MUL_MB;
            end else begin
              pass_r <= P_COPY_B2M;
              have_r <= 1'b1;
            end
          end else begin
            state_r <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          exp_r <= exp_r >> 1;
          if ((exp_r >> 1) != 8'd0) begin
            pass_r  <= P_SQR_B;
            state_r <= S_RUN;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          out_tdata_r  <= '0;
          out_tuser_r  <= OP_COMPUTE;
          exp_r        <= '0;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "min_plus_matrix_power_assert.svh"

  // An item is only taken when its result has somewhere to go.
  `MPMP_ASSERT_NOW(a_slot_free, in_acc, !out_tvalid_r || out_tready, "item taken with output busy")
  // A compute item closes the input until its result is posted.
  `MPMP_ASSERT_NEXT(a_compute_busy, in_acc && in_op == OP_COMPUTE, !in_tready, "input open during compute")
  // Pass beats only follow an issue cycle.
  `MPMP_ASSERT_NEXT(a_beat_origin, state_r != S_RUN, !ctl1_r.valid, "stray accumulator beat")

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the min-plus matrix power block.
`timescale 1ns / 1ps
module tb;
  import mpmp_pkg::*;

  localparam int NV          = 16;
  localparam int CELLS       = NV * NV;
  localparam int IDLE_LIMIT  = 400000;  // watchdog limit; must outlast the longest compute at n=16
  localparam int DRAIN_WAIT  = 20;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct {
    logic [WeightW-1:0] weight;
    logic               exists;
    logic [1:0]         op;
  } path_result_t;

  // Scoreboard: shadow copy of the matrix store and the registers, plus a queue of
  // result beats still owed by the block.
  class path_scoreboard;
    entry_t       mat[CELLS];
    int unsigned  vcount;
    int unsigned  pwr;
    path_result_t owed[$];
    int           fails;

    function new();
      foreach (mat[i]) mat[i] = '0;
      vcount = 16;
      pwr    = 16;
      fails  = 0;
    endfunction

    function void set_reg(logic idx, logic [7:0] val);
      if (idx == CFG_VERTEX_COUNT) vcount = val[4:0];
      else pwr = val;
    endfunction

    // d = a (x) b over the active square; entries outside it are taken from a
    function automatic void minplus(input entry_t a[CELLS], input entry_t b[CELLS],
                                    input int n, output entry_t d[CELLS]);
      entry_t best;
      logic [WeightW:0] s;
      d = a;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          best = '0;
          for (int k = 0; k < n; k++) begin
            if (a[i*NV+k][WeightW] && b[k*NV+j][WeightW]) begin
              s = a[i*NV+k][WeightW-1:0] + b[k*NV+j][WeightW-1:0];
              if (s[WeightW]) s = {1'b0, {WeightW{1'b1}}};  // saturate
              if (!best[WeightW] || s[WeightW-1:0] < best[WeightW-1:0])
                best = {1'b1, s[WeightW-1:0]};
            end
          end
          d[i*NV+j] = best;
        end
    endfunction

    function automatic void raise_power();
      entry_t base[CELLS];
      entry_t prod[CELLS];
      int n;
      int unsigned e;
      bit have_acc;
      n = (vcount > NV) ? NV : vcount;
      e = (pwr == 0) ? 1 : pwr;
      have_acc = 0;
      base = mat;
      while (e != 0) begin
        if (e[0]) begin
          if (have_acc) begin
            minplus(mat, base, n, prod);
            mat = prod;
          end else begin
            for (int i = 0; i < n; i++)
              for (int j = 0; j < n; j++) mat[i*NV+j] = base[i*NV+j];
            have_acc = 1;
          end
        end
        e = e >> 1;
        if (e != 0) begin
          minplus(base, base, n, prod);
          base = prod;
        end
      end
    endfunction

    function void note_input(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                             logic [15:0] weight, logic present);
      path_result_t r;
      if (op == OP_NONE) return;
      r.weight = '0;
      r.exists = 1'b0;
      r.op     = op;
      case (op)
        OP_WRITE:   mat[row*NV+col] = present ? {1'b1, 8'd0, weight} : '0;
        OP_COMPUTE: raise_power();
        default: begin
          r.weight = mat[row*NV+col][WeightW-1:0];
          r.exists = mat[row*NV+col][WeightW];
        end
      endcase
      owed.push_back(r);
    endfunction

    function void check_result(logic [31:0] tdata, logic [1:0] tuser);
      path_result_t r;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result beat tdata=%h tuser=%0d", $time, tdata, tuser);
        fails++;
        return;
      end
      r = owed.pop_front();
      if (tuser !== r.op) begin
        $display("%0t: op_done expected %0d actual %0d", $time, r.op, tuser);
        fails++;
      end
      if (tdata[WeightW] !== r.exists) begin
        $display("%0t: path_exists expected %0d actual %0d", $time, r.exists,
                 tdata[WeightW]);
        fails++;
      end
      if (tdata[WeightW-1:0] !== r.weight) begin
        $display("%0t: path_weight expected %0d actual %0d", $time, r.weight,
                 tdata[WeightW-1:0]);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;

  path_scoreboard sb = new();
  bit  no_idle = 0;    // phases with back-to-back beats on both sides
  int  idle_cycles = 0;

  min_plus_matrix_power #(.MAX_VERTICES(NV)) u_dut (.*);

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (no_idle) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 99) < 70);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                           logic [15:0] weight, logic present);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, present, weight, col, row};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, row, col, weight, present);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);  // an ignored item may still be in flight
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_regs(logic [7:0] vc, logic [7:0] pw);
    wait_drained();
    write_reg(CFG_VERTEX_COUNT, vc);
    write_reg(CFG_POWER, pw);
  endtask

  // random item; computes rare, and rarer still when the square is large
  task automatic random_item(int compute_pct);
    int r;
    logic [15:0] w;
    logic [3:0] row, col;
    r   = $urandom_range(0, 99);
    row = (sb.vcount > 0 && $urandom_range(0, 3) != 0) ?
          4'($urandom_range(0, (sb.vcount > NV ? NV : sb.vcount) - 1)) :
          4'($urandom_range(0, 15));
    col = (sb.vcount > 0 && $urandom_range(0, 3) != 0) ?
          4'($urandom_range(0, (sb.vcount > NV ? NV : sb.vcount) - 1)) :
          4'($urandom_range(0, 15));
    w   = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 65535)) :
          16'($urandom_range(0, 50));
    if (r < compute_pct)
      send_item(OP_COMPUTE, row, col, w, 1'($urandom_range(0, 1)));
    else if (r < 3 + compute_pct)
      send_item(OP_NONE, row, col, w, 1'($urandom_range(0, 1)));
    else if (r < 55)
      send_item(OP_WRITE, row, col, w, ($urandom_range(0, 9) != 0));
    else
      send_item(OP_READ, row, col, w, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [7:0] vc, pw;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: defaults first (n=16, power 16)
    send_item(OP_READ, 4'd0, 4'd0, 16'hFFFF, 1'b1);      // absent after reset
    send_item(OP_WRITE, 4'd0, 4'd0, 16'hFFFF, 1'b1);
    send_item(OP_WRITE, 4'd15, 4'd15, 16'h0000, 1'b1);
    send_item(OP_WRITE, 4'd3, 4'd4, 16'd123, 1'b0);      // stored absent
    send_item(OP_NONE, 4'd1, 4'd1, 16'd7, 1'b1);
    send_item(OP_READ, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(OP_READ, 4'd15, 4'd15, 16'd0, 1'b0);
    send_item(OP_READ, 4'd3, 4'd4, 16'd0, 1'b0);
    send_item(OP_WRITE, 4'd0, 4'd1, 16'd2, 1'b1);
    send_item(OP_WRITE, 4'd1, 4'd0, 16'd3, 1'b1);
    send_item(OP_COMPUTE, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(OP_READ, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(OP_READ, 4'd0, 4'd1, 16'd0, 1'b0);
    // power 0 acts as 1
    set_regs(8'd4, 8'd0);
    send_item(OP_COMPUTE, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(OP_READ, 4'd0, 4'd0, 16'd0, 1'b0);
    // empty square leaves everything alone
    set_regs(8'd0, 8'd255);
    send_item(OP_COMPUTE, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(OP_READ, 4'd15, 4'd15, 16'd0, 1'b0);
    // oversized count, full power; a repeat pushes the heavy loop into saturation
    set_regs(8'd31, 8'd255);
    send_item(OP_WRITE, 4'd0, 4'd0, 16'hFFFF, 1'b1);
    send_item(OP_COMPUTE, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(OP_READ, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(OP_COMPUTE, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(OP_READ, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(OP_READ, 4'd15, 4'd15, 16'd0, 1'b0);

    // random phases; the drain before each register write is the full pause
    for (int ph = 0; ph < 13; ph++) begin
      if (ph == 5 || ph == 11) begin
        vc = (ph == 5) ? 8'd16 : 8'd20;
        pw = 8'($urandom_range(1, 255));
      end else begin
        vc = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
             8'($urandom_range(1, 6));
        pw = ($urandom_range(0, 5) == 0) ? 8'd1 : 8'($urandom_range(0, 255));
      end
      set_regs(vc, pw);
      no_idle = (ph % 4 == 3);
      for (int i = 0; i < 50; i++)
        random_item((vc[4:0] >= 10) ? 1 : 6);
    end

    no_idle = 0;
    wait_drained();
    if (sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
